/* design/assert_macros.svh */
// assertion macros used by the rtl top level
// expects clk and rst_n to be visible at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, also while reset is asserted
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

// check on every rising edge outside of reset
`define ASSERT_ACTIVE(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

/* design/qp_pkg.sv */
// shared types and codes for the process queue with priority removal
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qp_pkg;

    // field widths
    localparam int REQ_W    = 2;
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // default number of queue entries
    localparam int QP_DEPTH_DEFAULT = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_APPEND     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP        = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE_MIN = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // one stored queue entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } qp_entry_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT
    } qp_state_t;

endpackage

`default_nettype wire

/* design/qp_ram.sv */
// simple dual-port entry memory, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module qp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/fifo_with_min_priority_extract.sv */
// top level: process queue with head pop and lowest-priority removal
// depends on qp_pkg, qp_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// Ordered queue of QUEUE_DEPTH (id, priority) words kept in a circular buffer in one
// memory with a registered read. A request is taken when start is high and busy is low;
// its result shows on the result ports for exactly one cycle with done high, and the
// receiver cannot stall it. occupancy is valid with done. Append, a refused request or
// an unused code complete without leaving the idle state; pop reads the head word, and
// remove-min scans all n entries and then shifts the n - 1 - p words behind the removed
// word at position p. The single memory read port sets this pace: removal reads every
// entry once to find the minimum, then moves each later entry one place toward the head,
// one word per cycle. busy is high while a pop or removal runs and low again with done.
module fifo_with_min_priority_extract #(
    parameter int QUEUE_DEPTH = qp_pkg::QP_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [qp_pkg::REQ_W-1:0]      req_type,
    input  wire logic [qp_pkg::ID_W-1:0]       proc_id,
    input  wire logic [qp_pkg::PRIO_W-1:0]     proc_priority,
    output logic                               done,
    output logic      [qp_pkg::STATUS_W-1:0]   status,
    output logic      [qp_pkg::ID_W-1:0]       out_id,
    output logic      [qp_pkg::PRIO_W-1:0]     out_priority,
    output logic      [qp_pkg::OCC_W-1:0]      occupancy
);

    import qp_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 2;

    // control state
    qp_state_t         state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              done_reg, done_next;

    // scan and shift bookkeeping
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     best_pos_reg, best_pos_next;
    qp_entry_t         best_reg, best_next;

    // result payload
    logic [STATUS_W-1:0] status_reg, status_next;
    qp_entry_t           result_reg, result_next;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    qp_entry_t     mem_wdata;
    logic [AW-1:0] mem_raddr;
    qp_entry_t     mem_rdata;

    // helpers
    logic [CW-1:0]      last_idx;
    logic [CW-1:0]      idx_inc1;
    logic [CW-1:0]      idx_inc2;
    logic               take_new;
    qp_entry_t          cand;
    logic [CW-1:0]      cand_pos;
    logic [CW+OCC_W-1:0] occ_wide;

    // logical position to physical memory address
    function automatic logic [AW-1:0] phys_addr(
        input logic [CW-1:0] k,
        input logic [AW-1:0] h
    );
        logic [SW-1:0] sum;
        sum = SW'(h) + SW'(k);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    qp_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(qp_entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // derived indexes and the running minimum
    assign last_idx = count_reg - CW'(1);
    assign idx_inc1 = idx_reg + CW'(1);
    assign idx_inc2 = idx_reg + CW'(2);
    assign take_new = (idx_reg == '0) || (mem_rdata.prio < best_reg.prio);
    assign cand     = take_new ? mem_rdata : best_reg;
    assign cand_pos = take_new ? idx_reg : best_pos_reg;

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload and bookkeeping registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_pos_reg <= best_pos_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
    end

    // sequencer: next state, memory accesses and result
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        idx_next      = idx_reg;
        best_pos_next = best_pos_reg;
        best_next     = best_reg;
        status_next   = status_reg;
        result_next   = result_reg;
        mem_we        = 1'b0;
        mem_waddr     = phys_addr(count_reg, head_reg);
        mem_wdata     = '{id: proc_id, prio: proc_priority};
        mem_raddr     = phys_addr(idx_inc1, head_reg);

        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = head_reg;
                idx_next  = '0;
                if (start)
                begin
                    result_next = '0;
                    status_next = ST_OK;
                    case (req_type)
                        REQ_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        REQ_REMOVE_MIN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // head word arrives from memory
            S_POP:
            begin
                result_next = mem_rdata;
                head_next   = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
                count_next  = count_reg - CW'(1);
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            // one word per cycle, first minimum from the head wins
            S_SCAN:
            begin
                best_next     = cand;
                best_pos_next = cand_pos;
                idx_next      = idx_inc1;
                if (idx_reg == last_idx)
                begin
                    if (cand_pos == last_idx)
                    begin
                        result_next = cand;
                        count_next  = count_reg - CW'(1);
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        mem_raddr  = phys_addr(cand_pos + CW'(1), head_reg);
                        idx_next   = cand_pos;
                        state_next = S_SHIFT;
                    end
                end
            end

            // move word idx+1 down to idx, closing the gap
            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = phys_addr(idx_reg, head_reg);
                mem_wdata = mem_rdata;
                mem_raddr = phys_addr(idx_inc2, head_reg);
                idx_next  = idx_inc1;
                if (idx_inc1 == last_idx)
                begin
                    result_next = best_reg;
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    assign occ_wide     = {{OCC_W{1'b0}}, count_reg};
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_id       = result_reg.id;
    assign out_priority = result_reg.prio;
    assign occupancy    = occ_wide[OCC_W-1:0];

    // checks
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "entry count above depth")
    `ASSERT_ACTIVE(a_done_idle, done_reg |-> (state_reg == S_IDLE), "result while still busy")
    `ASSERT_ACTIVE(a_append_one_cycle, (start && !busy && req_type == REQ_APPEND) |=> done_reg, "append result late")
    `ASSERT_ACTIVE(a_full_count, (done_reg && status_reg == ST_FULL) |-> (count_reg == CW'(QUEUE_DEPTH)), "full status below depth")

endmodule

`default_nettype wire
